@@ rtl/tcg_pkg.sv @@
package tcg_pkg;

   localparam int MAX_COLS    = 256;
   localparam int MAX_ROWS    = 128;
   localparam int TAB_WIDTH   = 4;
   localparam int MAX_RESULTS = 4;
   localparam int CELL_PAST   = 32768;
   localparam int COL_SAT     = 511;
   localparam int QUEUE_DEPTH = 4;

   localparam int GRID_CAP  = MAX_COLS * MAX_ROWS;
   localparam int CELL_CAP  = (GRID_CAP < CELL_PAST) ? GRID_CAP : CELL_PAST;
   localparam int TAB_CELLS = (TAB_WIDTH < MAX_RESULTS) ? TAB_WIDTH : MAX_RESULTS;

   localparam int POS_W      = 32;
   localparam int LINES_W    = 20;
   localparam int COL_W      = 9;
   localparam int ROW_W      = 8;
   localparam int CELL_W     = 15;
   localparam int PTR_W      = CELL_W + 1;
   localparam int GLYPH_W    = 8;
   localparam int STYLE_W    = 2;
   localparam int KIND_W     = 2;
   localparam int BEAT_W     = $clog2(MAX_RESULTS + 1);
   localparam int TAB_CNT_W  = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [GLYPH_W-1:0] CHAR_NL  = 8'h0A;
   localparam logic [GLYPH_W-1:0] CHAR_TAB = 8'h09;

   localparam logic [STYLE_W-1:0] STYLE_NONE  = 2'b00;
   localparam logic [STYLE_W-1:0] STYLE_INV   = 2'b01;
   localparam logic [STYLE_W-1:0] STYLE_BLINK = 2'b10;

   localparam logic OP_TEXT = 1'b0;
   localparam logic OP_END  = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCROLL_LINES = 2'd0,
      CSR_CURSOR_POS   = 2'd1,
      CSR_GRID_COLS    = 2'd2,
      CSR_GRID_ROWS    = 2'd3
   } csr_index_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_GLYPH     = 2'd0,
      KIND_STYLE     = 2'd1,
      KIND_FRAME_END = 2'd2
   } kind_type;

   typedef struct packed {
      logic                is_end;
      kind_type            kind;
      logic [CELL_W-1:0]   addr;
      logic [BEAT_W-1:0]   count;
      logic [GLYPH_W-1:0]  glyph;
      logic [STYLE_W-1:0]  style;
      logic [POS_W-1:0]    first_pos;
      logic [POS_W-1:0]    end_pos;
   } tcg_job_type;

endpackage

@@ rtl/tcg_ifs.sv @@
interface tcg_req_if;
   import tcg_pkg::*;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic [GLYPH_W-1:0] byte_value;

   modport source (output valid, output opcode, output byte_value, input ready);
   modport sink (input valid, input opcode, input byte_value, output ready);
endinterface

interface tcg_rsp_if;
   import tcg_pkg::*;
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [CELL_W-1:0]  cell_addr;
   logic [GLYPH_W-1:0] glyph_code;
   logic [STYLE_W-1:0] style_bits;
   logic [POS_W-1:0]   first_pos;
   logic [POS_W-1:0]   end_pos;
   logic               last_of_run;

   modport source (output valid, output kind, output cell_addr, output glyph_code,
                   output style_bits, output first_pos, output end_pos,
                   output last_of_run, input ready);
   modport sink (input valid, input kind, input cell_addr, input glyph_code,
                 input style_bits, input first_pos, input end_pos,
                 input last_of_run, output ready);
endinterface

@@ rtl/tcg_front.sv @@
module tcg_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [tcg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tcg_pkg::CSR_DATA_W-1:0]   csr_wdata,
   tcg_req_if.sink                          req,
   input  logic                             q_full,
   output logic                             q_push,
   output tcg_pkg::tcg_job_type             q_job
);
   import tcg_pkg::*;

   typedef enum logic [1:0] {
      PH_SKIP,
      PH_BETWEEN,
      PH_INROW,
      PH_FULL
   } phase_type;

   localparam logic [PTR_W:0] CELL_PAST_X = (PTR_W + 1)'(CELL_PAST);
   localparam logic [COL_W:0] COL_SAT_X   = (COL_W + 1)'(COL_SAT);

   logic [LINES_W-1:0]   scroll_ff;
   logic [POS_W-1:0]     cursor_ff;
   logic [COL_W-1:0]     cols_ff;
   logic [ROW_W-1:0]     rows_ff;

   phase_type            phase_ff, phase_in;
   logic [POS_W-1:0]     bp_ff, bp_in;
   logic [LINES_W-1:0]   ls_ff, ls_in;
   logic [POS_W-1:0]     start_ff, start_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [TAB_CNT_W-1:0] tcol_ff, tcol_in;
   logic [PTR_W-1:0]     cp_ff, cp_in;

   logic [COL_W+ROW_W-1:0] grid_cells;
   logic [PTR_W-1:0]       lim;
   logic                   accept;
   logic                   at_cur;
   logic                   in_grid;
   logic [ROW_W:0]         end_row;
   logic [COL_W-1:0]       col_gap;
   logic [COL_W-1:0]       spaces;
   logic [PTR_W-1:0]       cell_room;

   function automatic logic [PTR_W-1:0] sat_cell(input logic [PTR_W:0] sum);
      sat_cell = (sum > CELL_PAST_X) ? PTR_W'(CELL_PAST) : sum[PTR_W-1:0];
   endfunction

   function automatic logic [COL_W-1:0] sat_col(input logic [COL_W:0] sum);
      sat_col = (sum > COL_SAT_X) ? COL_W'(COL_SAT) : sum[COL_W-1:0];
   endfunction

   assign grid_cells = cols_ff * rows_ff;
   assign lim = ((COL_W + ROW_W)'(CELL_CAP) < grid_cells) ? PTR_W'(CELL_CAP)
                                                          : PTR_W'(grid_cells);
   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;

   always_comb begin
      phase_in  = phase_ff;
      bp_in     = bp_ff;
      ls_in     = ls_ff;
      start_in  = start_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      tcol_in   = tcol_ff;
      cp_in     = cp_ff;
      q_push    = 1'b0;
      at_cur    = 1'b0;
      in_grid   = 1'b0;
      col_gap   = '0;
      spaces    = '0;
      cell_room = '0;
      end_row   = '0;
      q_job           = '0;
      q_job.kind      = KIND_STYLE;
      q_job.count     = BEAT_W'(1);
      if (accept) begin
         if (req.opcode == OP_END) begin
            unique case (phase_ff)
               PH_SKIP:    end_row = '0;
               PH_BETWEEN: end_row = {1'b0, row_ff};
               PH_INROW:   end_row = {1'b0, row_ff} + 1'b1;
               PH_FULL:    end_row = {1'b0, rows_ff};
               default:    end_row = '0;
            endcase
            q_push          = 1'b1;
            q_job.is_end    = 1'b1;
            q_job.kind      = KIND_STYLE;
            q_job.addr      = cp_ff[CELL_W-1:0];
            q_job.style     = STYLE_INV;
            q_job.first_pos = (phase_ff == PH_SKIP) ? bp_ff : start_ff;
            q_job.end_pos   = bp_ff;
            if (bp_ff == cursor_ff && col_ff < cols_ff && end_row < {1'b0, rows_ff}
                && cp_ff < lim) begin
               q_job.count = BEAT_W'(2);
            end
            phase_in = PH_SKIP;
            bp_in    = '0;
            ls_in    = '0;
            start_in = '0;
            row_in   = '0;
            col_in   = '0;
            tcol_in  = '0;
            cp_in    = '0;
         end else begin
            if (phase_in == PH_SKIP) begin
               if (ls_ff < scroll_ff) begin
                  if (req.byte_value == CHAR_NL) begin
                     ls_in = ls_ff + 1'b1;
                  end
                  bp_in = bp_ff + 1'b1;
               end else begin
                  start_in = bp_ff;
                  row_in   = '0;
                  col_in   = '0;
                  tcol_in  = '0;
                  cp_in    = '0;
                  phase_in = PH_BETWEEN;
               end
            end
            if (phase_in == PH_INROW && col_in >= cols_ff) begin
               row_in   = row_in + 1'b1;
               phase_in = PH_BETWEEN;
            end
            if (phase_in == PH_BETWEEN) begin
               if (row_in >= rows_ff || cols_ff == '0) begin
                  phase_in = PH_FULL;
               end else begin
                  col_in   = '0;
                  tcol_in  = '0;
                  phase_in = PH_INROW;
               end
            end
            if (phase_in == PH_INROW) begin
               at_cur  = (bp_ff == cursor_ff);
               in_grid = (cp_in < lim);
               q_job.addr = cp_in[CELL_W-1:0];
               if (req.byte_value == CHAR_NL) begin
                  q_push      = at_cur && in_grid;
                  q_job.style = STYLE_INV | STYLE_BLINK;
                  col_gap     = cols_ff - col_in;
                  cp_in       = sat_cell({1'b0, cp_in} + (PTR_W + 1)'(col_gap));
                  row_in      = row_in + 1'b1;
                  phase_in    = PH_BETWEEN;
               end else if (req.byte_value == CHAR_TAB) begin
                  q_push      = at_cur && in_grid;
                  q_job.style = STYLE_INV | STYLE_BLINK;
                  cell_room   = lim - cp_in;
                  q_job.count = (cell_room < PTR_W'(TAB_CELLS)) ? BEAT_W'(cell_room)
                                                               : BEAT_W'(TAB_CELLS);
                  spaces      = COL_W'(TAB_WIDTH) - COL_W'(tcol_in);
                  cp_in       = sat_cell({1'b0, cp_in} + (PTR_W + 1)'(spaces));
                  col_in      = sat_col({1'b0, col_in} + (COL_W + 1)'(spaces));
                  tcol_in     = '0;
               end else begin
                  q_push      = in_grid;
                  q_job.kind  = KIND_GLYPH;
                  q_job.glyph = req.byte_value;
                  q_job.style = at_cur ? (STYLE_INV | STYLE_BLINK) : STYLE_NONE;
                  cp_in       = sat_cell({1'b0, cp_in} + (PTR_W + 1)'(1));
                  col_in      = sat_col({1'b0, col_in} + (COL_W + 1)'(1));
                  tcol_in     = (tcol_in == TAB_CNT_W'(TAB_WIDTH - 1)) ? '0
                                                                      : tcol_in + 1'b1;
               end
               bp_in = bp_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_ff <= '0;
         cursor_ff <= '0;
         cols_ff   <= COL_W'(80);
         rows_ff   <= ROW_W'(25);
         phase_ff  <= PH_SKIP;
         bp_ff     <= '0;
         ls_ff     <= '0;
         start_ff  <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
         tcol_ff   <= '0;
         cp_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_SCROLL_LINES: scroll_ff <= csr_wdata[LINES_W-1:0];
               CSR_CURSOR_POS:   cursor_ff <= csr_wdata[POS_W-1:0];
               CSR_GRID_COLS:    cols_ff   <= csr_wdata[COL_W-1:0];
               CSR_GRID_ROWS:    rows_ff   <= csr_wdata[ROW_W-1:0];
               default:          scroll_ff <= scroll_ff;
            endcase
         end
         phase_ff <= phase_in;
         bp_ff    <= bp_in;
         ls_ff    <= ls_in;
         start_ff <= start_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         tcol_ff  <= tcol_in;
         cp_ff    <= cp_in;
      end
   end

endmodule

@@ rtl/tcg_queue.sv @@
module tcg_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tcg_pkg::tcg_job_type push_job,
   output logic                 full,
   input  logic                 pop,
   output tcg_pkg::tcg_job_type head_job,
   output logic                 empty
);
   import tcg_pkg::*;

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   tcg_job_type         slots [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] ptr);
      next_ptr = (ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign full     = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = slots[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ rtl/tcg_back.sv @@
module tcg_back (
   input  logic                 clock,
   input  logic                 reset,
   input  tcg_pkg::tcg_job_type head_job,
   input  logic                 empty,
   output logic                 pop,
   tcg_rsp_if.source            rsp
);
   import tcg_pkg::*;

   logic                valid_ff;
   logic [BEAT_W-1:0]   beat_ff, beat_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [CELL_W-1:0]   cell_ff, cell_in;
   logic [GLYPH_W-1:0]  glyph_ff, glyph_in;
   logic [STYLE_W-1:0]  style_ff, style_in;
   logic [POS_W-1:0]    first_ff, first_in;
   logic [POS_W-1:0]    end_ff, end_in;
   logic                last_ff, last_in;
   logic                load;

   assign load    = !empty && (!valid_ff || rsp.ready);
   assign last_in = (beat_ff == head_job.count - 1'b1);
   assign pop     = load && last_in;

   always_comb begin
      beat_in = beat_ff;
      if (load) begin
         beat_in = last_in ? '0 : beat_ff + 1'b1;
      end
      if (head_job.is_end && last_in) begin
         kind_in  = KIND_FRAME_END;
         cell_in  = '0;
         glyph_in = '0;
         style_in = STYLE_NONE;
         first_in = head_job.first_pos;
         end_in   = head_job.end_pos;
      end else begin
         kind_in  = head_job.kind;
         cell_in  = head_job.addr + CELL_W'(beat_ff);
         glyph_in = head_job.glyph;
         style_in = head_job.style;
         first_in = '0;
         end_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= '0;
      end else begin
         beat_ff <= beat_in;
         if (load) begin
            valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= kind_in;
         cell_ff  <= cell_in;
         glyph_ff <= glyph_in;
         style_ff <= style_in;
         first_ff <= first_in;
         end_ff   <= end_in;
         last_ff  <= last_in;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.kind        = kind_ff;
   assign rsp.cell_addr   = cell_ff;
   assign rsp.glyph_code  = glyph_ff;
   assign rsp.style_bits  = style_ff;
   assign rsp.first_pos   = first_ff;
   assign rsp.end_pos     = end_ff;
   assign rsp.last_of_run = last_ff;

endmodule

@@ rtl/text_to_cell_grid_layout.sv @@
// Lays a text byte stream into a character cell grid and emits cell writes, style
// marks and a frame-end record. One request is taken per clock; a request whose
// results wait behind the output does not stall input until the four-entry job
// queue fills. Results leave at one per clock from the output register while
// the receiver is ready; a cursor tab gives up to four style marks and an end
// request with a cursor mark gives two results. The first result of a request
// passes through the job queue and then the output register. Configuration
// takes effect on the clock after the write.
module text_to_cell_grid_layout (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [tcg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcg_pkg::CSR_DATA_W-1:0] csr_wdata,
   tcg_req_if.sink                        req_bus,
   tcg_rsp_if.source                      rsp_bus
);
   import tcg_pkg::*;

   tcg_job_type push_job;
   tcg_job_type head_job;
   logic        q_push;
   logic        q_full;
   logic        q_pop;
   logic        q_empty;

   tcg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_bus),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   tcg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .head_job (head_job),
      .empty    (q_empty)
   );

   tcg_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .empty    (q_empty),
      .pop      (q_pop),
      .rsp      (rsp_bus)
   );

endmodule

@@ rtl/tcg_checker.sv @@
module tcg_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [tcg_pkg::KIND_W-1:0]    kind,
   input logic [tcg_pkg::CELL_W-1:0]    cell_addr,
   input logic [tcg_pkg::STYLE_W-1:0]   style_bits,
   input logic [tcg_pkg::POS_W-1:0]     first_pos,
   input logic [tcg_pkg::POS_W-1:0]     end_pos,
   input logic                          last_of_run
);
   import tcg_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(kind) && $stable(cell_addr)
         && $stable(last_of_run))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_frame_end_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind == KIND_FRAME_END |-> last_of_run && cell_addr == '0
         && style_bits == STYLE_NONE)
      else $error("malformed frame end");

   a_cell_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind != KIND_FRAME_END |-> (kind == KIND_GLYPH || kind == KIND_STYLE)
         && first_pos == '0 && end_pos == '0)
      else $error("malformed cell result");

   a_glyph_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind == KIND_GLYPH |-> last_of_run)
      else $error("glyph write not last of its request");

endmodule

bind text_to_cell_grid_layout tcg_checker u_tcg_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .kind        (rsp_bus.kind),
   .cell_addr   (rsp_bus.cell_addr),
   .style_bits  (rsp_bus.style_bits),
   .first_pos   (rsp_bus.first_pos),
   .end_pos     (rsp_bus.end_pos),
   .last_of_run (rsp_bus.last_of_run)
);
